// File: hdl/sit_pkg.sv
// Shared types, constants and helpers for the spherical inversion pipeline.
package sit_pkg;

   localparam int NUM_W = 56;   // dividend width: 32-bit magnitude shifted up by 24
   localparam int DIV_W = 41;   // divisor width: Q16.24 radius, up to 2*min_radius_sq
   localparam int W_W   = 34;   // offset point before inversion

   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_SCALE = 3'd1;
   localparam logic [2:0] REG_FOLD  = 3'd2;
   localparam logic [2:0] REG_MINR  = 3'd3;
   localparam logic [2:0] REG_PRE   = 3'd4;
   localparam logic [2:0] REG_INNER = 3'd5;
   localparam logic [2:0] REG_POST  = 3'd6;
   localparam logic [2:0] REG_DADJ  = 3'd7;

   localparam int MODE_ORIG    = 0;
   localparam int MODE_COND    = 1;
   localparam int MODE_CLAMP   = 2;
   localparam int MODE_REFLECT = 3;
   localparam int MODE_DEADJ   = 4;

   localparam logic [63:0] HUGE_COORD = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic [4:0]  mode_flags;
      logic [31:0] scale_factor;
      logic [39:0] fold_limit;
      logic [39:0] min_radius_sq;
      logic [62:0] pre_offset;
      logic [62:0] inner_offset;
      logic [62:0] post_offset;
      logic [63:0] de_adjust;
   } sit_cfg_type;

   // Data that rides alongside the divider
   typedef struct packed {
      logic [2:0][W_W-1:0] w;
      logic [2:0]          neg;
      logic [2:0]          nz;
      logic                inv;
      logic                den_zero;
      logic [31:0]         de1;
      logic                flag;
   } sit_side_type;

   // Q4.16 component widened to Q8.24, sign-extended to 64 bits
   function automatic logic [63:0] off64(input logic [62:0] r, input logic [1:0] lane);
      logic [20:0] b;
      b = r[21*lane +: 21];
      return {{35{b[20]}}, b, 8'h00};
   endfunction

endpackage

// File: hdl/sit_front.sv
// Front stages: offset, scale, DE update, squared radius and divisor selection.
module sit_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][31:0]                   in_pt,
   input  logic [31:0]                        in_de,
   input  sit_pkg::sit_cfg_type               cfg,
   output logic                               out_valid,
   output logic [3:0][sit_pkg::NUM_W-1:0]     out_num,
   output logic [sit_pkg::DIV_W-1:0]          out_den,
   output sit_pkg::sit_side_type              out_side
);

   logic [4:0] vld_ff;

   // stage A
   logic [2:0][31:0] c_a_ff;
   logic [2:0][32:0] a_a_ff;
   logic [63:0]      dep_a_ff;
   // stage B
   logic [2:0][31:0] c_b_ff;
   logic signed [64:0] prod_b_ff [3];
   logic [31:0]      de1_b_ff;
   logic             flag_b_ff;
   // stage C
   logic [2:0][31:0] s_c_ff;
   logic [2:0][31:0] v_c_ff;
   logic [31:0]      de1_c_ff;
   logic             flag_c_ff;
   // stage D
   logic [2:0][31:0] s_d_ff;
   logic [2:0][63:0] sq_d_ff;
   logic [31:0]      de1_d_ff;
   logic             flag_d_ff;
   // stage E
   logic [2:0][sit_pkg::W_W-1:0] w_e_ff;
   logic [39:0]      rr_e_ff;
   logic [31:0]      de1_e_ff;
   logic             flag_e_ff;

   logic [31:0] asc;
   logic [40:0] dsum;
   logic [2:0][31:0] s_in;
   logic [2:0]  sat_c;
   logic [63:0] sq_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   assign asc  = cfg.scale_factor[31] ? 32'(32'd0 - cfg.scale_factor) : cfg.scale_factor;
   assign dsum = {1'b0, dep_a_ff[63:24]} + 41'd65536;

   always_comb begin
      logic [40:0] sh;
      for (int i = 0; i < 3; i++) begin
         sh = prod_b_ff[i][64:24];
         sat_c[i] = 1'b0;
         s_in[i]  = sh[31:0];
         if (!sh[40] && (|sh[39:31])) begin
            sat_c[i] = 1'b1;
            s_in[i]  = 32'h7FFF_FFFF;
         end else if (sh[40] && !(&sh[39:31])) begin
            sat_c[i] = 1'b1;
            s_in[i]  = 32'h8000_0000;
         end
      end
   end

   assign sq_sum = sq_d_ff[0] + sq_d_ff[1] + sq_d_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         logic [63:0] off;
         for (int i = 0; i < 3; i++) begin
            off = sit_pkg::off64(cfg.pre_offset, 2'(i));
            c_a_ff[i] <= in_pt[i];
            a_a_ff[i] <= {in_pt[i][31], in_pt[i]} + off[32:0];
            c_b_ff[i] <= c_a_ff[i];
            prod_b_ff[i] <= 65'($signed(a_a_ff[i])) * 65'($signed(cfg.scale_factor));
            s_c_ff[i] <= s_in[i];
            v_c_ff[i] <= cfg.mode_flags[sit_pkg::MODE_ORIG] ? c_b_ff[i] : s_in[i];
            s_d_ff[i] <= s_c_ff[i];
            sq_d_ff[i] <= 64'($signed(v_c_ff[i])) * 64'($signed(v_c_ff[i]));
            off = sit_pkg::off64(cfg.inner_offset, 2'(i));
            if (cfg.mode_flags[sit_pkg::MODE_COND]) begin
               w_e_ff[i] <= {{2{s_d_ff[i][31]}}, s_d_ff[i]} + off[33:0];
            end else begin
               w_e_ff[i] <= {{2{s_d_ff[i][31]}}, s_d_ff[i]};
            end
         end
         dep_a_ff  <= 64'(in_de) * 64'(asc);
         flag_b_ff <= |dsum[40:32];
         de1_b_ff  <= (|dsum[40:32]) ? 32'hFFFF_FFFF : dsum[31:0];
         de1_c_ff  <= de1_b_ff;
         flag_c_ff <= flag_b_ff | (|sat_c);
         de1_d_ff  <= de1_c_ff;
         flag_d_ff <= flag_c_ff;
         rr_e_ff   <= sq_sum[63:24];
         de1_e_ff  <= de1_d_ff;
         flag_e_ff <= flag_d_ff;
      end
   end

   // Divisor choice and dividend magnitudes, registered by the first divider stage
   always_comb begin
      logic lt_fold, lt_min, cond;
      logic [sit_pkg::DIV_W-1:0] refl;
      logic [sit_pkg::W_W-1:0]   mag;
      cond    = cfg.mode_flags[sit_pkg::MODE_COND];
      lt_fold = rr_e_ff < cfg.fold_limit;
      lt_min  = rr_e_ff < cfg.min_radius_sq;
      refl    = {cfg.min_radius_sq, 1'b0} - {1'b0, rr_e_ff};
      if (cond && cfg.mode_flags[sit_pkg::MODE_REFLECT] && lt_min) begin
         out_den = refl;
      end else if (cond && cfg.mode_flags[sit_pkg::MODE_CLAMP] && lt_min) begin
         out_den = {1'b0, cfg.min_radius_sq};
      end else begin
         out_den = {1'b0, rr_e_ff};
      end
      for (int i = 0; i < 3; i++) begin
         mag = w_e_ff[i][sit_pkg::W_W-1] ? (sit_pkg::W_W'(0) - w_e_ff[i]) : w_e_ff[i];
         out_num[i]         = {mag[31:0], 24'h000000};
         out_side.neg[i]    = w_e_ff[i][sit_pkg::W_W-1];
         out_side.nz[i]     = |w_e_ff[i];
      end
      out_num[3]        = {de1_e_ff, 24'h000000};
      out_side.w        = w_e_ff;
      out_side.inv      = !cond || lt_fold;
      out_side.den_zero = out_den == '0;
      out_side.de1      = de1_e_ff;
      out_side.flag     = flag_e_ff;
   end

   assign out_valid = vld_ff[4];

endmodule

// File: hdl/sit_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing a divisor.
module sit_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [3:0][sit_pkg::NUM_W-1:0]     in_num,
   input  logic [sit_pkg::DIV_W-1:0]          in_den,
   input  sit_pkg::sit_side_type              in_side,
   output logic                               out_valid,
   output logic [3:0][sit_pkg::NUM_W-1:0]     out_quo,
   output sit_pkg::sit_side_type              out_side
);

   localparam int NS = sit_pkg::NUM_W;
   localparam int DW = sit_pkg::DIV_W;

   logic [NS-1:0]                     vld_ff;
   logic [3:0][sit_pkg::NUM_W-1:0]    nq_ff  [NS];
   logic [3:0][DW-1:0]                rem_ff [NS];
   logic [DW-1:0]                     den_ff [NS];
   sit_pkg::sit_side_type             side_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                           vld_src;
      logic [3:0][sit_pkg::NUM_W-1:0] nq_src, nq_in;
      logic [3:0][DW-1:0]             rem_src, rem_in;
      logic [DW-1:0]                  den_src;
      sit_pkg::sit_side_type          side_src;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign nq_src   = in_num;
         assign rem_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign nq_src   = nq_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         logic [DW:0] t, d;
         logic        ge;
         for (int l = 0; l < 4; l++) begin
            t  = {rem_src[l], nq_src[l][sit_pkg::NUM_W-1]};
            ge = t >= {1'b0, den_src};
            d  = t - {1'b0, den_src};
            rem_in[l] = ge ? d[DW-1:0] : t[DW-1:0];
            nq_in[l]  = {nq_src[l][sit_pkg::NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]   <= nq_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = nq_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

// File: hdl/sit_back.sv
// Back stages: sign restore, offsets, saturation and DE adjust.
module sit_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [3:0][sit_pkg::NUM_W-1:0]     in_quo,
   input  sit_pkg::sit_side_type              in_side,
   input  sit_pkg::sit_cfg_type               cfg,
   output logic                               out_valid,
   output logic [2:0][31:0]                   out_pt,
   output logic [31:0]                        out_de,
   output logic                               out_sat
);

   logic [2:0] vld_ff;

   logic [2:0][63:0] r_g_ff;
   logic [31:0]      de_g_ff;
   logic             flag_g_ff;

   logic [2:0][31:0] pt_h_ff;
   logic signed [64:0] dprod_h_ff;
   logic [31:0]      de_h_ff;
   logic             flag_h_ff;

   logic [2:0][31:0] pt_i_ff;
   logic [31:0]      de_i_ff;
   logic             flag_i_ff;

   logic [2:0][63:0] r_in;
   logic [31:0]      de_in;
   logic             flag_in;
   logic [2:0][31:0] pt_sat;
   logic [2:0]       sat_h;
   logic [31:0]      de_adj;
   logic             adj_flag;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_comb begin
      logic [63:0] val;
      logic [63:0] q;
      flag_in = in_side.flag | (in_side.inv & in_side.den_zero);
      for (int i = 0; i < 3; i++) begin
         q = {8'h00, in_quo[i]};
         if (!in_side.inv) begin
            val = {{(64-sit_pkg::W_W){in_side.w[i][sit_pkg::W_W-1]}}, in_side.w[i]};
         end else if (in_side.den_zero) begin
            if (in_side.neg[i]) begin
               val = 64'd0 - sit_pkg::HUGE_COORD;
            end else if (in_side.nz[i]) begin
               val = sit_pkg::HUGE_COORD;
            end else begin
               val = '0;
            end
         end else begin
            val = in_side.neg[i] ? (64'd0 - q) : q;
         end
         if (cfg.mode_flags[sit_pkg::MODE_COND]) begin
            val = val - sit_pkg::off64(cfg.inner_offset, 2'(i));
         end
         r_in[i] = val - sit_pkg::off64(cfg.pre_offset, 2'(i))
                       - sit_pkg::off64(cfg.post_offset, 2'(i));
      end
      if (!in_side.inv) begin
         de_in = in_side.de1;
      end else if (in_side.den_zero) begin
         de_in = (in_side.de1 != '0) ? 32'hFFFF_FFFF : 32'h0;
      end else if (|in_quo[3][sit_pkg::NUM_W-1:32]) begin
         de_in   = 32'hFFFF_FFFF;
         flag_in = 1'b1;
      end else begin
         de_in = in_quo[3][31:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat_h[i]  = 1'b0;
         pt_sat[i] = r_g_ff[i][31:0];
         if (!r_g_ff[i][63] && (|r_g_ff[i][62:31])) begin
            sat_h[i]  = 1'b1;
            pt_sat[i] = 32'h7FFF_FFFF;
         end else if (r_g_ff[i][63] && !(&r_g_ff[i][62:31])) begin
            sat_h[i]  = 1'b1;
            pt_sat[i] = 32'h8000_0000;
         end
      end
   end

   always_comb begin
      logic [41:0] adj;
      adj = {dprod_h_ff[64], dprod_h_ff[64:24]}
          + {{10{cfg.de_adjust[31]}}, cfg.de_adjust[31:0]};
      adj_flag = 1'b0;
      de_adj   = adj[31:0];
      if (adj[41]) begin
         adj_flag = 1'b1;
         de_adj   = '0;
      end else if (|adj[40:32]) begin
         adj_flag = 1'b1;
         de_adj   = 32'hFFFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_g_ff     <= r_in;
         de_g_ff    <= de_in;
         flag_g_ff  <= flag_in;
         pt_h_ff    <= pt_sat;
         dprod_h_ff <= 65'($signed({1'b0, de_g_ff})) * 65'($signed(cfg.de_adjust[63:32]));
         de_h_ff    <= de_g_ff;
         flag_h_ff  <= flag_g_ff | (|sat_h);
         pt_i_ff    <= pt_h_ff;
         if (cfg.mode_flags[sit_pkg::MODE_DEADJ]) begin
            de_i_ff   <= de_adj;
            flag_i_ff <= flag_h_ff | adj_flag;
         end else begin
            de_i_ff   <= de_h_ff;
            flag_i_ff <= flag_h_ff;
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign out_pt    = pt_i_ff;
   assign out_de    = de_i_ff;
   assign out_sat   = flag_i_ff;

endmodule

// File: hdl/spherical_inversion_transform.sv
// Spherical inversion transform: top level with register file and pipeline.
// Pipeline: 5 front stages, 56 divider stages (one quotient bit each), 3 back stages.
// Throughput one item per cycle; the whole pipeline holds while the output item waits.
// Synchronous active-high reset clears all valid bits and loads register defaults.
// Results go through an output register; req_tready follows rsp_tready when full.
module spherical_inversion_transform (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // in_x, in_y, in_z, in_de
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_x, out_y, out_z, out_de
   output logic [0:0]   rsp_tuser,   // saturated
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   sit_pkg::sit_cfg_type cfg_ff;
   logic en;
   logic cfg_wr;
   logic [2:0] cfg_idx;

   logic                              f_valid;
   logic [3:0][sit_pkg::NUM_W-1:0]    f_num;
   logic [sit_pkg::DIV_W-1:0]         f_den;
   sit_pkg::sit_side_type             f_side;
   logic                              d_valid;
   logic [3:0][sit_pkg::NUM_W-1:0]    d_quo;
   sit_pkg::sit_side_type             d_side;
   logic [2:0][31:0]                  o_pt;
   logic [31:0]                       o_de;
   logic                              o_sat;

   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[5:3];
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_flags    <= '0;
         cfg_ff.scale_factor  <= 32'h0100_0000;
         cfg_ff.fold_limit    <= 40'h00_0100_0000;
         cfg_ff.min_radius_sq <= 40'h00_0080_0000;
         cfg_ff.pre_offset    <= '0;
         cfg_ff.inner_offset  <= '0;
         cfg_ff.post_offset   <= '0;
         cfg_ff.de_adjust     <= 64'h0100_0000_0000_0000;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            sit_pkg::REG_MODE:  cfg_ff.mode_flags    <= csr_pwdata[4:0];
            sit_pkg::REG_SCALE: cfg_ff.scale_factor  <= csr_pwdata[31:0];
            sit_pkg::REG_FOLD:  cfg_ff.fold_limit    <= csr_pwdata[39:0];
            sit_pkg::REG_MINR:  cfg_ff.min_radius_sq <= csr_pwdata[39:0];
            sit_pkg::REG_PRE:   cfg_ff.pre_offset    <= csr_pwdata[62:0];
            sit_pkg::REG_INNER: cfg_ff.inner_offset  <= csr_pwdata[62:0];
            sit_pkg::REG_POST:  cfg_ff.post_offset   <= csr_pwdata[62:0];
            sit_pkg::REG_DADJ:  cfg_ff.de_adjust     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         sit_pkg::REG_MODE:  csr_prdata = 64'(cfg_ff.mode_flags);
         sit_pkg::REG_SCALE: csr_prdata = 64'(cfg_ff.scale_factor);
         sit_pkg::REG_FOLD:  csr_prdata = 64'(cfg_ff.fold_limit);
         sit_pkg::REG_MINR:  csr_prdata = 64'(cfg_ff.min_radius_sq);
         sit_pkg::REG_PRE:   csr_prdata = 64'(cfg_ff.pre_offset);
         sit_pkg::REG_INNER: csr_prdata = 64'(cfg_ff.inner_offset);
         sit_pkg::REG_POST:  csr_prdata = 64'(cfg_ff.post_offset);
         sit_pkg::REG_DADJ:  csr_prdata = cfg_ff.de_adjust;
         default:            csr_prdata = '0;
      endcase
   end

   // pipeline advances unless a finished item is held at the output
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   sit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_pt     ({req_tdata[95:64], req_tdata[63:32], req_tdata[31:0]}),
      .in_de     (req_tdata[127:96]),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_side  (f_side)
   );

   sit_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   sit_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_quo    (d_quo),
      .in_side   (d_side),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_pt    (o_pt),
      .out_de    (o_de),
      .out_sat   (o_sat)
   );

   assign rsp_tdata = {o_de, o_pt[2], o_pt[1], o_pt[0]};
   assign rsp_tuser = o_sat;

endmodule

// File: verif/spherical_inversion_transform_test.sv
// Testbench for the spherical inversion transform: directed and random points against a predictor.
`timescale 1ns / 1ps

module spherical_inversion_transform_test;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] de;
      logic        sat;
   } point_result_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // in_x, in_y, in_z, in_de
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // out_x, out_y, out_z, out_de
   logic [0:0]   rsp_tuser;         // saturated
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [5:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   spherical_inversion_transform uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // predictor copy of the register file
   logic [4:0]  cur_mode;
   logic [31:0] cur_scale;
   logic [39:0] cur_fold;
   logic [39:0] cur_minr;
   logic [62:0] cur_pre;
   logic [62:0] cur_inner;
   logic [62:0] cur_post;
   logic [63:0] cur_dadj;

   point_result_type pending_results[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   function automatic longint offset_q824(input logic [62:0] r, input int lane);
      logic [20:0] b;
      b = r[21*lane +: 21];
      return longint'($signed(b)) * 256;
   endfunction

   function automatic longint clip32(input longint v, inout bit f);
      if (v > 64'sd2147483647) begin
         f = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         f = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint invert_coord(input longint v, input logic [63:0] d, inout bit f);
      logic [63:0] mag;
      logic [63:0] q;
      if (d == 0) begin
         f = 1'b1;
         return v > 0 ? 64'sd1152921504606846976 : (v < 0 ? -64'sd1152921504606846976 : 0);
      end
      mag = v < 0 ? -v : v;
      q = (mag << 24) / d;
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [63:0] invert_de(input logic [63:0] v, input logic [63:0] d,
                                            inout bit f);
      logic [63:0] q;
      if (d == 0) begin
         f = 1'b1;
         return v != 0 ? 64'hFFFF_FFFF : 64'h0;
      end
      q = (v << 24) / d;
      if (q > 64'hFFFF_FFFF) begin
         f = 1'b1;
         q = 64'hFFFF_FFFF;
      end
      return q;
   endfunction

   function automatic point_result_type transform_point(input logic [127:0] item);
      point_result_type res;
      bit f;
      longint sc, c[3], s[3], w[3], r, ds, dof, v;
      logic [63:0] asc, de1, de, sum, rr, m;
      f = 1'b0;
      sum = 0;
      sc = longint'($signed(cur_scale));
      asc = sc < 0 ? -sc : sc;
      for (int i = 0; i < 3; i++) begin
         c[i] = longint'($signed(item[32*i +: 32]));
         s[i] = clip32((c[i] + offset_q824(cur_pre, i)) * sc >>> 24, f);
      end
      de1 = ((64'(item[127:96]) * asc) >> 24) + 64'd65536;
      if (de1 > 64'hFFFF_FFFF) begin
         f = 1'b1;
         de1 = 64'hFFFF_FFFF;
      end
      for (int i = 0; i < 3; i++) begin
         v = cur_mode[sit_pkg::MODE_ORIG] ? c[i] : s[i];
         sum += v * v;
      end
      rr = sum >> 24;
      de = de1;
      if (!cur_mode[sit_pkg::MODE_COND]) begin
         for (int i = 0; i < 3; i++) w[i] = invert_coord(s[i], rr, f);
         de = invert_de(de1, rr, f);
      end else begin
         for (int i = 0; i < 3; i++) w[i] = s[i] + offset_q824(cur_inner, i);
         if (rr < cur_fold) begin
            m = rr;
            if (cur_mode[sit_pkg::MODE_CLAMP] && rr < cur_minr) m = 64'(cur_minr);
            // reflect wins over clamp
            if (cur_mode[sit_pkg::MODE_REFLECT] && rr < cur_minr) m = 2 * 64'(cur_minr) - rr;
            for (int i = 0; i < 3; i++) w[i] = invert_coord(w[i], m, f);
            de = invert_de(de1, m, f);
         end
         for (int i = 0; i < 3; i++) w[i] -= offset_q824(cur_inner, i);
      end
      res.x = 32'(clip32(w[0] - offset_q824(cur_pre, 0) - offset_q824(cur_post, 0), f));
      res.y = 32'(clip32(w[1] - offset_q824(cur_pre, 1) - offset_q824(cur_post, 1), f));
      res.z = 32'(clip32(w[2] - offset_q824(cur_pre, 2) - offset_q824(cur_post, 2), f));
      if (cur_mode[sit_pkg::MODE_DEADJ]) begin
         ds = longint'($signed(cur_dadj[63:32]));
         dof = longint'($signed(cur_dadj[31:0]));
         r = ((longint'(de) * ds) >>> 24) + dof;
         if (r < 0) begin
            f = 1'b1;
            r = 0;
         end
         if (r > 64'sd4294967295) begin
            f = 1'b1;
            r = 64'sd4294967295;
         end
         de = r;
      end
      res.de = de[31:0];
      res.sat = f;
      return res;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         sit_pkg::REG_MODE:  cur_mode = value[4:0];
         sit_pkg::REG_SCALE: cur_scale = value[31:0];
         sit_pkg::REG_FOLD:  cur_fold = value[39:0];
         sit_pkg::REG_MINR:  cur_minr = value[39:0];
         sit_pkg::REG_PRE:   cur_pre = value[62:0];
         sit_pkg::REG_INNER: cur_inner = value[62:0];
         sit_pkg::REG_POST:  cur_post = value[62:0];
         sit_pkg::REG_DADJ:  cur_dadj = value;
      endcase
   endtask

   // must be called at a falling edge
   task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] de);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {de, z, y, x};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(transform_point(req_tdata));
      @(negedge clock);
   endtask

   // must be called at a falling edge
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom_range(32'd67108864) - 32'd33554432;   // within +-2.0
         1: return $urandom_range(32'd2097152) - 32'd1048576;     // near origin
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [39:0] rand_radius();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 40'({$urandom, $urandom});
         default: return 40'($urandom_range(32'h0400_0000));
      endcase
   endfunction

   task automatic random_settings();
      logic [31:0] sc;
      case ($urandom_range(4))
         0: sc = 32'h8000_0000;
         1: sc = 32'h7FFF_FFFF;
         2: sc = 32'h0100_0000;
         default: sc = $urandom_range(32'h0800_0000) - 32'h0400_0000;
      endcase
      csr_write(sit_pkg::REG_MODE, 64'($urandom_range(31)));
      csr_write(sit_pkg::REG_SCALE, {{32{sc[31]}}, sc});
      csr_write(sit_pkg::REG_FOLD, 64'(rand_radius()));
      csr_write(sit_pkg::REG_MINR, 64'(rand_radius()));
      csr_write(sit_pkg::REG_PRE, $urandom_range(1) ? {$urandom, $urandom} : 64'h0);
      csr_write(sit_pkg::REG_INNER, $urandom_range(1) ? {$urandom, $urandom} : 64'h0);
      csr_write(sit_pkg::REG_POST, $urandom_range(1) ? {$urandom, $urandom} : 64'h0);
      csr_write(sit_pkg::REG_DADJ, $urandom_range(1) ? {$urandom, $urandom}
                                           : {$urandom_range(32'h0200_0000), $urandom});
   endtask

   task automatic test_reset_defaults();
      cur_mode = 5'd0;
      cur_scale = 32'h0100_0000;
      cur_fold = 40'h00_0100_0000;
      cur_minr = 40'h00_0080_0000;
      cur_pre = '0;
      cur_inner = '0;
      cur_post = '0;
      cur_dadj = 64'h0100_0000_0000_0000;
      @(negedge clock);
      send_point(32'h0, 32'h0, 32'h0, 32'h0);                   // zero radius
      send_point(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
      send_point(32'h0100_0000, 32'h0, 32'h0, 32'h0001_0000);   // unit point
      send_point(32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 32'h0);   // tiny radius
      send_point(32'h0080_0000, 32'hFF80_0000, 32'h0, 32'h0010_0000);
      wait_idle();
   endtask

   task automatic test_mode_cases();
      // conditional with clamp and reflect together, point inside min radius
      csr_write(sit_pkg::REG_MODE, 64'(5'b01110));
      send_point(32'h0020_0000, 32'h0, 32'h0, 32'h0001_0000);
      send_point(32'h0, 32'h0, 32'h0, 32'h0001_0000);            // zero radius, conditional
      send_point(32'h0300_0000, 32'h0, 32'h0, 32'h0001_0000);    // outside fold limit
      wait_idle();
      csr_write(sit_pkg::REG_MODE, 64'(5'b00110));               // clamp only
      send_point(32'h0020_0000, 32'h0010_0000, 32'h0, 32'h0002_0000);
      send_point(32'h00C0_0000, 32'h0, 32'h0, 32'h0002_0000);
      wait_idle();
      csr_write(sit_pkg::REG_MODE, 64'(5'b11001));               // clamp/reflect ignored
      csr_write(sit_pkg::REG_DADJ, {32'h8000_0000, 32'h7FFF_FFFF});
      send_point(32'h0020_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
      wait_idle();
      csr_write(sit_pkg::REG_DADJ, {32'h7FFF_FFFF, 32'h8000_0000});
      send_point(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h1234_5678);
      wait_idle();
      csr_write(sit_pkg::REG_MODE, 64'(5'b00010));
      csr_write(sit_pkg::REG_SCALE, 64'hFFFF_FFFF_8000_0000);
      csr_write(sit_pkg::REG_FOLD, 64'h0000_00FF_FFFF_FFFF);
      csr_write(sit_pkg::REG_PRE, 64'h7FFF_FFFF_FFFF_FFFF);
      csr_write(sit_pkg::REG_INNER, 64'h4000_0100_0002_0000);
      csr_write(sit_pkg::REG_POST, 64'h0000_0100_0000_0001);
      send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
      send_point(32'h0000_1000, 32'h0, 32'h0, 32'h0);
      wait_idle();
      csr_write(sit_pkg::REG_SCALE, 64'h0);
      csr_write(sit_pkg::REG_MINR, 64'h0000_00FF_FFFF_FFFF);
      csr_write(sit_pkg::REG_MODE, 64'(5'b01010));               // reflect, max min radius
      send_point(32'h0100_0000, 32'h0, 32'h0, 32'h0001_0000);
      wait_idle();
      csr_write(sit_pkg::REG_MODE, 64'(5'b00011));
   endtask

   task automatic test_random_points(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         random_settings();
         @(negedge clock);
         repeat (per_phase) send_point(rand_coord(), rand_coord(), rand_coord(),
                                       $urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000));
         wait_idle();
      end
   endtask

   // receiver ready, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual %h sat %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== {want.de, want.z, want.y, want.x} || rsp_tuser[0] !== want.sat) begin
               errors++;
               $display("%0t: mismatch expected x=%h y=%h z=%h de=%h sat=%b,",
                        $time, want.x, want.y, want.z, want.de, want.sat,
                        " actual x=%h y=%h z=%h de=%h sat=%b",
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tdata[127:96], rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 64;
      test_reset_defaults();
      test_mode_cases();
      test_random_points(10, 30);
      send_idle_pct = 64;
      recv_idle_pct = 38;
      test_random_points(10, 30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_points(10, 30);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
